>>> design/lops_pkg.sv
package lops_pkg;

    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int Q_SHIFT = 16;
    localparam int TERM_W  = MUL_P_W - Q_SHIFT;
    localparam int SUM_W   = 84;
    localparam int ADDR_W  = 5;

    localparam logic signed [SUM_W-1:0] BIAS_POS = 84'sd196608;
    localparam logic signed [SUM_W-1:0] BIAS_NEG = -84'sd196608;

    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;

    typedef enum logic [2:0] {
        REG_GAIN_P,
        REG_GAIN_I,
        REG_GAIN_D,
        REG_DEAD_BAND,
        REG_TIME_STEP,
        REG_INV_TIME_STEP
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CMP,
        S_M_TS,
        S_M_DV,
        S_M_GP,
        S_M_GI0,
        S_M_GI1,
        S_M_GD0,
        S_M_GD1,
        S_ACC,
        S_DONE
    } t_state;

endpackage

>>> design/lops_mul.sv
module lops_mul (
    input  logic                                  i_clk,
    input  logic signed [lops_pkg::MUL_A_W-1:0]   i_a,
    input  logic        [lops_pkg::MUL_B_W-1:0]   i_b,
    output logic signed [lops_pkg::MUL_P_W-1:0]   o_p
);

    logic signed [lops_pkg::MUL_P_W-1:0] prod;
    logic signed [lops_pkg::MUL_P_W-1:0] r_p;

    // signed operand times unsigned operand, exact
    assign prod = i_a * $signed({1'b0, i_b});

    always_ff @(posedge i_clk) begin
        r_p <= prod;
    end

    assign o_p = r_p;

endmodule

>>> design/lane_offset_pid_steering.sv
// Sequence: an item inside the dead band goes from the compare straight to the output load;
// a corrected item takes the compare, seven passes through the shared 33x32
// multiplier, a final accumulate and the output load, in that order.
// A new item is accepted only when idle, after the last one has reached the output register.
// Reset (synchronous, active low): configuration registers take their reset values, reference and
// integral clear, the output register empties.
module lane_offset_pid_steering #(
    parameter int INTEGRAL_WIDTH = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [31:0]            i_deviation,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [31:0]            o_steering_angle,
    output logic                          o_correcting,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lops_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int IW   = INTEGRAL_WIDTH;
    localparam int TW   = lops_pkg::TERM_W;
    localparam int IS_W = ((IW > TW) ? IW : TW) + 1;
    localparam int SW   = lops_pkg::SUM_W;
    localparam int PW   = lops_pkg::MUL_P_W;
    localparam int QS   = lops_pkg::Q_SHIFT;

    localparam logic signed [IW-1:0] INT_MIN = {1'b1, {(IW-1){1'b0}}};
    localparam logic signed [IW-1:0] INT_MAX = {1'b0, {(IW-1){1'b1}}};

    lops_pkg::t_state r_state, n_state;

    logic [31:0] r_gp, r_gi, r_gd, r_ts, r_its;
    logic [30:0] r_db;

    logic signed [31:0]    r_ref;
    logic                  r_latched;
    logic signed [IW-1:0]  r_int;
    logic signed [31:0]    r_prev;
    logic                  r_out_valid;

    logic signed [31:0]    r_dev;
    logic signed [31:0]    r_e;
    logic signed [TW-1:0]  r_d;
    logic signed [SW-1:0]  r_sum;
    logic                  r_corr;
    logic signed [31:0]    r_angle;
    logic                  r_corr_out;

    logic signed [lops_pkg::MUL_A_W-1:0] mul_a;
    logic        [lops_pkg::MUL_B_W-1:0] mul_b;
    logic signed [PW-1:0]                mul_p;
    logic                                acc_en;
    logic                                acc_up;

    logic                  cfg_wr;
    lops_pkg::t_reg        cfg_idx;
    logic signed [32:0]    diff;
    logic        [32:0]    mag;
    logic                  cmp_within;
    logic signed [31:0]    e_sat;
    logic signed [63:0]    i64;
    logic signed [TW-1:0]  term;
    logic signed [IS_W-1:0] isum;
    logic                  int_ovf;
    logic signed [IW-1:0]  int_next;
    logic signed [SW-1:0]  add_val;
    logic                  sum_ovf;
    logic signed [31:0]    sum_sat;
    logic                  out_load;

    lops_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = lops_pkg::t_reg'(paddr[lops_pkg::ADDR_W-1:2]);

    always_comb begin
        unique case (cfg_idx)
            lops_pkg::REG_GAIN_P:        prdata = r_gp;
            lops_pkg::REG_GAIN_I:        prdata = r_gi;
            lops_pkg::REG_GAIN_D:        prdata = r_gd;
            lops_pkg::REG_DEAD_BAND:     prdata = {1'b0, r_db};
            lops_pkg::REG_TIME_STEP:     prdata = r_ts;
            lops_pkg::REG_INV_TIME_STEP: prdata = r_its;
            default:                     prdata = '0;
        endcase
    end

    // datapath helpers
    assign diff       = 33'(r_dev) - 33'(r_ref);
    assign mag        = diff[32] ? 33'(-diff) : 33'(diff);
    assign cmp_within = (mag <= {2'b00, r_db});
    assign e_sat      = (diff[32] != diff[31]) ? (diff[32] ? lops_pkg::S32_MIN
                                                           : lops_pkg::S32_MAX)
                                               : diff[31:0];

    assign i64  = 64'(r_int);
    assign term = $signed(mul_p[PW-1:QS]);
    assign isum = IS_W'(r_int) + IS_W'(term);
    assign int_ovf  = (isum[IS_W-1:IW-1] != {(IS_W-IW+1){isum[IS_W-1]}});
    assign int_next = int_ovf ? (isum[IS_W-1] ? INT_MIN : INT_MAX) : isum[IW-1:0];

    assign add_val = acc_up ? (SW'(mul_p) <<< QS) : SW'(term);

    assign sum_ovf = (r_sum[SW-1:31] != {(SW-31){r_sum[SW-1]}});
    assign sum_sat = sum_ovf ? (r_sum[SW-1] ? lops_pkg::S32_MIN : lops_pkg::S32_MAX)
                             : r_sum[31:0];

    assign out_load = (r_state == lops_pkg::S_DONE) && (!r_out_valid || i_out_ready);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lops_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        mul_a      = '0;
        mul_b      = '0;
        acc_en     = 1'b0;
        acc_up     = 1'b0;
        o_in_ready = 1'b0;
        unique case (r_state)
            lops_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = lops_pkg::S_CMP;
                end
            end
            lops_pkg::S_CMP: begin
                n_state = cmp_within ? lops_pkg::S_DONE : lops_pkg::S_M_TS;
            end
            lops_pkg::S_M_TS: begin
                mul_a   = 33'(r_e);
                mul_b   = r_ts;
                n_state = lops_pkg::S_M_DV;
            end
            lops_pkg::S_M_DV: begin
                mul_a   = 33'(r_e) - 33'(r_prev);
                mul_b   = r_its;
                n_state = lops_pkg::S_M_GP;
            end
            lops_pkg::S_M_GP: begin
                mul_a   = 33'(r_e);
                mul_b   = r_gp;
                n_state = lops_pkg::S_M_GI0;
            end
            lops_pkg::S_M_GI0: begin
                mul_a   = {1'b0, i64[31:0]};
                mul_b   = r_gi;
                acc_en  = 1'b1;
                n_state = lops_pkg::S_M_GI1;
            end
            lops_pkg::S_M_GI1: begin
                mul_a   = 33'($signed(i64[63:32]));
                mul_b   = r_gi;
                acc_en  = 1'b1;
                n_state = lops_pkg::S_M_GD0;
            end
            lops_pkg::S_M_GD0: begin
                mul_a   = {1'b0, r_d[31:0]};
                mul_b   = r_gd;
                acc_en  = 1'b1;
                acc_up  = 1'b1;
                n_state = lops_pkg::S_M_GD1;
            end
            lops_pkg::S_M_GD1: begin
                mul_a   = 33'($signed(r_d[TW-1:32]));
                mul_b   = r_gd;
                acc_en  = 1'b1;
                n_state = lops_pkg::S_ACC;
            end
            lops_pkg::S_ACC: begin
                acc_en  = 1'b1;
                acc_up  = 1'b1;
                n_state = lops_pkg::S_DONE;
            end
            lops_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = lops_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lops_pkg::S_IDLE;
            end
        endcase
    end

    // control and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gp        <= 32'd6554;
            r_gi        <= 32'd655;
            r_gd        <= 32'd3277;
            r_db        <= 31'd3277;
            r_ts        <= 32'd66;
            r_its       <= 32'd65536000;
            r_ref       <= '0;
            r_latched   <= 1'b0;
            r_int       <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (cfg_idx)
                    lops_pkg::REG_GAIN_P:        r_gp  <= pwdata;
                    lops_pkg::REG_GAIN_I:        r_gi  <= pwdata;
                    lops_pkg::REG_GAIN_D:        r_gd  <= pwdata;
                    lops_pkg::REG_DEAD_BAND:     r_db  <= pwdata[30:0];
                    lops_pkg::REG_TIME_STEP:     r_ts  <= pwdata;
                    lops_pkg::REG_INV_TIME_STEP: r_its <= pwdata;
                    default: ;
                endcase
            end
            // first negative sample becomes the reference
            if (r_state == lops_pkg::S_IDLE && i_in_valid && !r_latched && i_deviation[31]) begin
                r_ref     <= i_deviation;
                r_latched <= 1'b1;
            end
            if (r_state == lops_pkg::S_M_DV) begin
                r_int <= int_next;
            end
            if (r_state == lops_pkg::S_ACC) begin
                r_prev <= r_e;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_state == lops_pkg::S_IDLE && i_in_valid) begin
            r_dev <= i_deviation;
        end
        if (r_state == lops_pkg::S_CMP) begin
            r_corr <= !cmp_within;
            r_e    <= e_sat;
            r_sum  <= e_sat[31] ? lops_pkg::BIAS_POS : lops_pkg::BIAS_NEG;
        end
        if (r_state == lops_pkg::S_M_GP) begin
            r_d <= term;
        end
        if (acc_en) begin
            r_sum <= r_sum + add_val;
        end
        if (out_load) begin
            r_angle    <= r_corr ? sum_sat : '0;
            r_corr_out <= r_corr;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_steering_angle = r_angle;
    assign o_correcting     = r_corr_out;

    a_latch_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_latched |=> r_latched)
        else $error("reference latch dropped");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_correcting) |-> (o_steering_angle == 32'sd0))
        else $error("nonzero angle without correction");

    a_band_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lops_pkg::S_CMP && cmp_within) |=> ($stable(r_int) && $stable(r_prev)))
        else $error("state changed inside dead band");

    a_accept_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == lops_pkg::S_CMP))
        else $error("transfer did not start compare");

endmodule
